>>> rtl/utv_pkg.sv
// Shared types and constants for the UTF-8 text validator.
package utv_pkg;

    // Byte classification limits
    localparam logic [7:0] ASCII_CTRL_END = 8'h20;
    localparam logic [7:0] ASCII_DEL      = 8'h7f;
    localparam logic [7:0] ASCII_END      = 8'h80;
    localparam logic [7:0] LEAD2_LO       = 8'hc2;
    localparam logic [7:0] LEAD2_HI       = 8'hdf;
    localparam logic [7:0] LEAD3_LO       = 8'he0;
    localparam logic [7:0] LEAD3_HI       = 8'hef;
    localparam logic [7:0] LEAD4_LO       = 8'hf0;
    localparam logic [7:0] LEAD4_HI       = 8'hf4;
    localparam logic [1:0] CONT_TAG       = 2'b10;

    // Code point limits
    localparam logic [20:0] CP_MIN2      = 21'h000080;
    localparam logic [20:0] CP_MIN3      = 21'h000800;
    localparam logic [20:0] CP_MIN4      = 21'h010000;
    localparam logic [20:0] CP_MAX       = 21'h10ffff;
    localparam logic [20:0] CP_SURR_LO   = 21'h00d800;
    localparam logic [20:0] CP_SURR_HI   = 21'h00dfff;

    // Lead classes: number of continuation bytes a lead calls for
    localparam logic [1:0] CLASS_NONE = 2'd0;
    localparam logic [1:0] CLASS_TWO  = 2'd1;
    localparam logic [1:0] CLASS_THREE = 2'd2;
    localparam logic [1:0] CLASS_FOUR = 2'd3;

    // One input word
    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
        logic       no_data;
    } utv_item_t;

    // Per-string decode state (length count kept apart, its width follows the limit)
    typedef struct packed {
        logic        error_seen;
        logic [1:0]  bytes_pending;
        logic [20:0] code_accum;
        logic [1:0]  lead_class;
    } utv_state_t;

    // Verdict produced by one word
    typedef struct packed {
        logic emit;
        logic verdict;
    } utv_result_t;

endpackage

>>> rtl/utf8_text_validator_unit.sv
// Top level: UTF-8 string validator, one byte per word, one verdict per string.
// The verdict is registered in the output stage when the final (or no_data) word moves on from the input stage.
// Throughput: one byte per cycle; the single decode step between the input and
// result registers sets this figure, stalling only while an unread verdict blocks.
// Reset: rst_n clears both stage valids and the decode state; the next word starts a string.
module utf8_text_validator_unit
#(
    parameter int MAX_TEXT_BYTES = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_value,
    input  logic       last_byte,
    input  logic       no_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_valid
);
    import utv_pkg::*;

    localparam int CNT_W = $clog2(MAX_TEXT_BYTES + 2);

    utv_item_t        item_in;
    utv_item_t        item;
    logic             item_valid;
    logic             advance;
    logic             out_free;
    utv_state_t       state_reg;
    utv_state_t       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    utv_result_t      result;

    assign item_in.byte_value = byte_value;
    assign item_in.last_byte  = last_byte;
    assign item_in.no_data    = no_data;

    utv_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item_in    (item_in),
        .advance    (advance),
        .item_valid (item_valid),
        .item_out   (item)
    );

    utv_step
    #(
        .MAX_TEXT_BYTES (MAX_TEXT_BYTES),
        .CNT_W          (CNT_W)
    )
    u_step
    (
        .item      (item),
        .state_cur (state_reg),
        .count_cur (count_reg),
        .state_new (state_next),
        .count_new (count_next),
        .result    (result)
    );

    // Move the held word on unless its verdict has nowhere to go
    assign advance = item_valid && (!result.emit || out_free);

    // Commit decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            count_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    utv_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .result    (result),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .is_valid  (is_valid)
    );

endmodule

>>> rtl/utv_in_stage.sv
// Input register stage: holds one accepted word until the check stage takes it.
module utv_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  utv_pkg::utv_item_t item_in,
    input  logic              advance,
    output logic              item_valid,
    output utv_pkg::utv_item_t item_out
);
    import utv_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    utv_item_t item_reg;

    // Accept when empty or when the held word moves on this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_valid ? 1'b1 : (advance ? 1'b0 : valid_reg);

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item_out   = item_reg;

endmodule

>>> rtl/utv_step.sv
// Combinational check of one byte against the running UTF-8 decode state.
module utv_step
#(
    parameter int MAX_TEXT_BYTES = 64,
    parameter int CNT_W          = 7
)
(
    input  utv_pkg::utv_item_t   item,
    input  utv_pkg::utv_state_t  state_cur,
    input  logic [CNT_W-1:0]     count_cur,
    output utv_pkg::utv_state_t  state_new,
    output logic [CNT_W-1:0]     count_new,
    output utv_pkg::utv_result_t result
);
    import utv_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TEXT_BYTES);

    utv_state_t       st;
    logic [CNT_W-1:0] cnt;
    logic [20:0]      cp;
    logic [7:0]       b;

    always_comb
    begin
        st     = state_cur;
        cnt    = count_cur;
        b      = item.byte_value;
        cp     = {state_cur.code_accum[14:0], b[5:0]};
        result = '0;

        if (item.no_data)
        begin
            // Empty or absent string: invalid verdict, drop state
            result.emit    = 1'b1;
            result.verdict = 1'b0;
            st             = '0;
            cnt            = '0;
        end
        else
        begin
            // Count bytes, saturating one past the limit
            if (cnt <= MAX_CNT)
            begin
                cnt = cnt + CNT_W'(1);
            end
            if (cnt > MAX_CNT)
            begin
                st.error_seen = 1'b1;
            end

            if (!st.error_seen)
            begin
                if (st.bytes_pending == 2'd0)
                begin
                    // Lead byte
                    if (b < ASCII_END)
                    begin
                        if (b < ASCII_CTRL_END || b == ASCII_DEL)
                        begin
                            st.error_seen = 1'b1;
                        end
                    end
                    else if (b >= LEAD2_LO && b <= LEAD2_HI)
                    begin
                        st.code_accum    = {16'd0, b[4:0]};
                        st.bytes_pending = 2'd1;
                        st.lead_class    = CLASS_TWO;
                    end
                    else if (b >= LEAD3_LO && b <= LEAD3_HI)
                    begin
                        st.code_accum    = {17'd0, b[3:0]};
                        st.bytes_pending = 2'd2;
                        st.lead_class    = CLASS_THREE;
                    end
                    else if (b >= LEAD4_LO && b <= LEAD4_HI)
                    begin
                        st.code_accum    = {18'd0, b[2:0]};
                        st.bytes_pending = 2'd3;
                        st.lead_class    = CLASS_FOUR;
                    end
                    else
                    begin
                        st.error_seen = 1'b1;
                    end
                end
                else if (b[7:6] != CONT_TAG)
                begin
                    st.error_seen = 1'b1;
                end
                else
                begin
                    // Continuation byte: shift in six bits
                    st.code_accum    = cp;
                    st.bytes_pending = st.bytes_pending - 2'd1;
                    if (st.bytes_pending == 2'd0)
                    begin
                        if ((st.lead_class == CLASS_TWO   && cp < CP_MIN2) ||
                            (st.lead_class == CLASS_THREE && cp < CP_MIN3) ||
                            (st.lead_class == CLASS_FOUR  && cp < CP_MIN4) ||
                            cp > CP_MAX ||
                            (cp >= CP_SURR_LO && cp <= CP_SURR_HI))
                        begin
                            st.error_seen = 1'b1;
                        end
                    end
                end
            end

            // End of string: cut-off sequence fails, then report and clear
            if (item.last_byte)
            begin
                result.emit    = 1'b1;
                result.verdict = !(st.error_seen || st.bytes_pending != 2'd0);
                st             = '0;
                cnt            = '0;
            end
        end

        state_new = st;
        count_new = cnt;
    end

endmodule

>>> rtl/utv_text_validator_unit.sv
// Output register stage: holds one verdict word until the consumer takes it.
module utv_out_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  utv_pkg::utv_result_t result,
    output logic                 free,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 is_valid
);
    import utv_pkg::*;

    logic valid_reg;
    logic valid_next;
    logic verdict_reg;

    // Slot is free when empty or being drained this cycle
    assign free       = !valid_reg || out_ready;
    assign valid_next = (load && result.emit) ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the verdict until taken
    always_ff @(posedge clk)
    begin
        if (load && result.emit)
        begin
            verdict_reg <= result.verdict;
        end
    end

    assign out_valid = valid_reg;
    assign is_valid  = verdict_reg;

endmodule
